[rtl/tfj_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfj_pkg
// Shared constants, command and status types of the text full justifier.
// ----------------------------------------------------------------------------
package tfj_pkg;

    // Sizes of the line store and the word list
    localparam int MAX_WIDTH = 128;
    localparam int MAX_WORDS = 64;

    localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
    localparam int LINE_AW = $clog2(MAX_WIDTH);
    localparam int WORDS_W = $clog2(MAX_WORDS + 1);
    localparam int WORD_AW = $clog2(MAX_WORDS);
    localparam int SUM_W   = (WIDTH_W + 2 > 9) ? WIDTH_W + 2 : 9;
    localparam int DCNT_W  = $clog2(WIDTH_W + 1);

    // Character codes
    localparam logic [7:0] CH_NL  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;

    // Configuration
    localparam logic [7:0] WIDTH_RESET    = 8'd80;
    localparam logic       REG_LINE_WIDTH = 1'b0;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_APPEND,
        OP_COPY_START,
        OP_COPY_STEP,
        OP_COPY_END,
        OP_LINE_START,
        OP_DIV_STEP,
        OP_RD_END,
        OP_LD_END,
        OP_RD_CH,
        OP_PUT_CH,
        OP_PUT_SP,
        OP_NEXT_WORD,
        OP_PUT_NL,
        OP_PUT_ERR
    } op_t;

    typedef struct packed {
        logic latch;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic is_letter;
        logic emit_after;
        logic plen_zero;
        logic plen_ge_w;
        logic plen_gt_w;
        logic need_flush;
        logic words_zero;
        logic copy_last;
        logic div_done;
        logic ch_more;
        logic gap_more;
        logic sp_more;
        logic pack_last;
        logic out_free;
    } stat_t;

endpackage

[rtl/tfj_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfj_stream_if
// Valid/ready channels for input characters and packed output items.
// ----------------------------------------------------------------------------
interface tfj_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       stream_end;

    modport source (output valid, output text_byte, output stream_end, input ready);
    modport sink   (input valid, input text_byte, input stream_end, output ready);
endinterface

interface tfj_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] packed_chars;
    logic [3:0]  char_count;
    logic        line_done;
    logic        word_too_long;

    modport source (output valid, output packed_chars, output char_count,
                    output line_done, output word_too_long, input ready);
    modport sink   (input valid, input packed_chars, input char_count,
                    input line_done, input word_too_long, output ready);
endinterface

[rtl/tfj_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfj_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tfj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/tfj_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfj_dpath
// Word and line stores, gap divider, byte packer and output register.
// ----------------------------------------------------------------------------
module tfj_dpath (
    input  logic          clk,
    input  logic          rst_n,
    input  tfj_pkg::cmd_t cmd,
    output tfj_pkg::stat_t stat,
    input  logic [7:0]    line_width,
    input  logic [7:0]    in_byte,
    input  logic          in_end,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [63:0]   out_chars,
    output logic [3:0]    out_count,
    output logic          out_done,
    output logic          out_err
);
    import tfj_pkg::*;

    logic [7:0]         byte_reg;
    logic               end_reg;
    logic [WIDTH_W-1:0] plen_reg, plen_next;
    logic [WIDTH_W-1:0] letters_reg, letters_next;
    logic [WORDS_W-1:0] words_reg, words_next;
    logic [WIDTH_W-1:0] c_reg, c_next;
    logic [WORDS_W-1:0] gaps_reg;
    logic [WIDTH_W-1:0] quo_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [WORDS_W-1:0] wi_reg;
    logic [WIDTH_W-1:0] ci_reg;
    logic [WIDTH_W-1:0] wend_reg;
    logic [WIDTH_W-1:0] spc_reg;
    logic [63:0]        acc_reg;
    logic [2:0]         pcnt_reg;
    logic               out_valid_reg;
    logic [63:0]        out_chars_reg;
    logic [3:0]         out_count_reg;
    logic               out_done_reg;
    logic               out_err_reg;

    logic [WIDTH_W-1:0] w_eff;
    logic [SUM_W-1:0]   lw_ext;
    logic [SUM_W-1:0]   fit_sum;
    logic [SUM_W-1:0]   total;
    logic [SUM_W-1:0]   rem_sh;
    logic               rem_ge;
    logic               is_nl;
    logic               is_sep;
    logic               out_free;
    logic               push_en;
    logic               push_last;
    logic [7:0]         push_byte;
    logic               xfer;
    logic [63:0]        acc_ins;
    logic [7:0]         pend_rdata;
    logic [7:0]         line_rdata;
    logic [WIDTH_W-1:0] ends_rdata;
    logic [WIDTH_W-1:0] line_waddr;
    logic [WIDTH_W-1:0] new_letters;

    // Clamp the configured width into 1..MAX_WIDTH
    always_comb
    begin
        lw_ext = SUM_W'(line_width);
        if (lw_ext == '0)
        begin
            w_eff = WIDTH_W'(1);
        end
        else if (lw_ext > SUM_W'(MAX_WIDTH))
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WIDTH_W'(line_width);
        end
    end

    // Classify the held character and the fit test
    assign is_nl       = (byte_reg == CH_NL);
    assign is_sep      = (byte_reg == CH_SP) || (byte_reg == CH_TAB);
    assign fit_sum     = SUM_W'(letters_reg) + SUM_W'(plen_reg) + SUM_W'(words_reg);
    assign new_letters = letters_reg + plen_reg;
    assign line_waddr  = letters_reg + c_reg - WIDTH_W'(1);
    assign out_free    = !out_valid_reg || out_ready;

    // Padding total for the line: at least one space per gap
    always_comb
    begin
        if (SUM_W'(w_eff) > SUM_W'(letters_reg))
        begin
            total = SUM_W'(w_eff) - SUM_W'(letters_reg);
        end
        else
        begin
            total = '0;
        end
        if (total < SUM_W'(words_reg - WORDS_W'(1)))
        begin
            total = SUM_W'(words_reg - WORDS_W'(1));
        end
    end

    // One restoring divide step
    assign rem_sh = {rem_reg[SUM_W-2:0], quo_reg[WIDTH_W-1]};
    assign rem_ge = (rem_sh >= SUM_W'(gaps_reg));

    always_comb
    begin
        stat.is_letter  = !is_nl && !is_sep;
        stat.emit_after = is_nl || end_reg;
        stat.plen_zero  = (plen_reg == '0);
        stat.plen_ge_w  = (plen_reg >= w_eff);
        stat.plen_gt_w  = (plen_reg > w_eff);
        stat.need_flush = (words_reg != '0) &&
                          ((fit_sum > SUM_W'(w_eff)) || (words_reg >= WORDS_W'(MAX_WORDS)));
        stat.words_zero = (words_reg == '0);
        stat.copy_last  = (c_reg == plen_reg);
        stat.div_done   = (dcnt_reg == DCNT_W'(WIDTH_W));
        stat.ch_more    = (ci_reg < wend_reg);
        stat.gap_more   = (wi_reg < gaps_reg);
        stat.sp_more    = (spc_reg != '0);
        stat.pack_last  = (pcnt_reg == 3'd7);
        stat.out_free   = out_free;
    end

    // Store the pending word
    tfj_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_pend (
        .clk   (clk),
        .we    (cmd.op == OP_APPEND),
        .waddr (plen_reg[LINE_AW-1:0]),
        .wdata (byte_reg),
        .re    ((cmd.op == OP_COPY_STEP) && (c_reg < plen_reg)),
        .raddr (c_reg[LINE_AW-1:0]),
        .rdata (pend_rdata)
    );

    // Store the letters of the open line
    tfj_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line (
        .clk   (clk),
        .we    ((cmd.op == OP_COPY_STEP) && (c_reg != '0)),
        .waddr (line_waddr[LINE_AW-1:0]),
        .wdata (pend_rdata),
        .re    (cmd.op == OP_RD_CH),
        .raddr (ci_reg[LINE_AW-1:0]),
        .rdata (line_rdata)
    );

    // Store the end offset of each word
    tfj_ram #(.WIDTH(WIDTH_W), .DEPTH(MAX_WORDS)) u_ends (
        .clk   (clk),
        .we    (cmd.op == OP_COPY_END),
        .waddr (words_reg[WORD_AW-1:0]),
        .wdata (new_letters),
        .re    (cmd.op == OP_RD_END),
        .raddr (wi_reg[WORD_AW-1:0]),
        .rdata (ends_rdata)
    );

    // Select the byte to pack
    always_comb
    begin
        push_en   = 1'b0;
        push_last = 1'b0;
        push_byte = CH_SP;
        unique case (cmd.op)
            OP_PUT_CH:
            begin
                push_en   = 1'b1;
                push_byte = line_rdata;
            end
            OP_PUT_SP:
            begin
                push_en = 1'b1;
            end
            OP_PUT_NL:
            begin
                push_en   = 1'b1;
                push_last = 1'b1;
                push_byte = CH_NL;
            end
            default:
            begin
                push_en = 1'b0;
            end
        endcase
        acc_ins = acc_reg;
        acc_ins[{pcnt_reg, 3'b000} +: 8] = push_byte;
        xfer = push_en && ((pcnt_reg == 3'd7) || push_last);
    end

    // Word, line and counter bookkeeping
    always_comb
    begin
        plen_next    = plen_reg;
        letters_next = letters_reg;
        words_next   = words_reg;
        c_next       = c_reg;
        unique case (cmd.op)
            OP_APPEND:     plen_next = plen_reg + WIDTH_W'(1);
            OP_COPY_START: c_next = '0;
            OP_COPY_STEP:  c_next = c_reg + WIDTH_W'(1);
            OP_COPY_END:
            begin
                letters_next = new_letters;
                words_next   = words_reg + WORDS_W'(1);
                plen_next    = '0;
            end
            OP_PUT_NL:
            begin
                letters_next = '0;
                words_next   = '0;
            end
            OP_PUT_ERR:
            begin
                letters_next = '0;
                words_next   = '0;
                plen_next    = '0;
            end
            default:
            begin
                plen_next = plen_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            letters_reg   <= '0;
            words_reg     <= '0;
            c_reg         <= '0;
            dcnt_reg      <= '0;
            acc_reg       <= '0;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg    <= plen_next;
            letters_reg <= letters_next;
            words_reg   <= words_next;
            c_reg       <= c_next;

            // Divider counter
            if (cmd.op == OP_LINE_START)
            begin
                dcnt_reg <= '0;
            end
            else if (cmd.op == OP_DIV_STEP)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end

            // Packer
            if (cmd.op == OP_LINE_START || xfer)
            begin
                acc_reg  <= '0;
                pcnt_reg <= '0;
            end
            else if (push_en)
            begin
                acc_reg  <= acc_ins;
                pcnt_reg <= pcnt_reg + 3'd1;
            end

            // Output register
            if (xfer || cmd.op == OP_PUT_ERR)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            byte_reg <= in_byte;
            end_reg  <= in_end;
        end

        unique case (cmd.op)
            OP_LINE_START:
            begin
                gaps_reg <= words_reg - WORDS_W'(1);
                quo_reg  <= WIDTH_W'(total);
                rem_reg  <= '0;
                wi_reg   <= '0;
                ci_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? rem_sh - SUM_W'(gaps_reg) : rem_sh;
                quo_reg <= {quo_reg[WIDTH_W-2:0], rem_ge};
            end
            OP_LD_END:
            begin
                wend_reg <= ends_rdata;
                spc_reg  <= quo_reg + WIDTH_W'(SUM_W'(wi_reg) < rem_reg);
            end
            OP_PUT_CH:    ci_reg <= ci_reg + WIDTH_W'(1);
            OP_PUT_SP:    spc_reg <= spc_reg - WIDTH_W'(1);
            OP_NEXT_WORD: wi_reg <= wi_reg + WORDS_W'(1);
            default:
            begin
                wi_reg <= wi_reg;
            end
        endcase

        if (xfer)
        begin
            out_chars_reg <= acc_ins;
            out_count_reg <= {1'b0, pcnt_reg} + 4'd1;
            out_done_reg  <= push_last;
            out_err_reg   <= 1'b0;
        end
        else if (cmd.op == OP_PUT_ERR)
        begin
            out_chars_reg <= '0;
            out_count_reg <= '0;
            out_done_reg  <= 1'b0;
            out_err_reg   <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_chars = out_chars_reg;
    assign out_count = out_count_reg;
    assign out_done  = out_done_reg;
    assign out_err   = out_err_reg;

endmodule

[rtl/tfj_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfj_ctrl
// Sequencer: word append, word commit, line justification and error halt.
// ----------------------------------------------------------------------------
module tfj_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output tfj_pkg::cmd_t  cmd,
    input  tfj_pkg::stat_t stat
);
    import tfj_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_DECODE = 15'b000000000000010,
        S_FIN    = 15'b000000000000100,
        S_CSTART = 15'b000000000001000,
        S_COPY   = 15'b000000000010000,
        S_CEND   = 15'b000000000100000,
        S_LINE   = 15'b000000001000000,
        S_DIV    = 15'b000000010000000,
        S_RDEND  = 15'b000000100000000,
        S_LDEND  = 15'b000001000000000,
        S_RDCH   = 15'b000010000000000,
        S_PUTCH  = 15'b000100000000000,
        S_SPACE  = 15'b001000000000000,
        S_NL     = 15'b010000000000000,
        S_ERR    = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   halted_reg, halted_next;
    logic   ret_copy_reg, ret_copy_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command
    always_comb
    begin
        state_next    = state_reg;
        halted_next   = halted_reg;
        ret_copy_next = ret_copy_reg;
        cmd.latch     = 1'b0;
        cmd.op        = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (halted_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.is_letter)
                begin
                    if (stat.plen_ge_w)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        cmd.op     = OP_APPEND;
                        state_next = stat.emit_after ? S_FIN : S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                priority if (stat.plen_zero)
                begin
                    ret_copy_next = 1'b0;
                    state_next    = stat.emit_after ? S_LINE : S_IDLE;
                end
                else if (stat.plen_gt_w)
                begin
                    state_next = S_ERR;
                end
                else if (stat.need_flush)
                begin
                    ret_copy_next = 1'b1;
                    state_next    = S_LINE;
                end
                else
                begin
                    state_next = S_CSTART;
                end
            end
            S_CSTART:
            begin
                cmd.op     = OP_COPY_START;
                state_next = S_COPY;
            end
            S_COPY:
            begin
                cmd.op = OP_COPY_STEP;
                if (stat.copy_last)
                begin
                    state_next = S_CEND;
                end
            end
            S_CEND:
            begin
                cmd.op        = OP_COPY_END;
                ret_copy_next = 1'b0;
                state_next    = stat.emit_after ? S_LINE : S_IDLE;
            end
            S_LINE:
            begin
                if (stat.words_zero)
                begin
                    state_next = ret_copy_reg ? S_CSTART : S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_LINE_START;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_RDEND;
                end
                else
                begin
                    cmd.op = OP_DIV_STEP;
                end
            end
            S_RDEND:
            begin
                cmd.op     = OP_RD_END;
                state_next = S_LDEND;
            end
            S_LDEND:
            begin
                cmd.op     = OP_LD_END;
                state_next = S_RDCH;
            end
            S_RDCH:
            begin
                priority if (stat.ch_more)
                begin
                    cmd.op     = OP_RD_CH;
                    state_next = S_PUTCH;
                end
                else if (stat.gap_more)
                begin
                    state_next = S_SPACE;
                end
                else
                begin
                    state_next = S_NL;
                end
            end
            S_PUTCH:
            begin
                if (!stat.pack_last || stat.out_free)
                begin
                    cmd.op     = OP_PUT_CH;
                    state_next = S_RDCH;
                end
            end
            S_SPACE:
            begin
                if (stat.sp_more)
                begin
                    if (!stat.pack_last || stat.out_free)
                    begin
                        cmd.op = OP_PUT_SP;
                    end
                end
                else
                begin
                    cmd.op     = OP_NEXT_WORD;
                    state_next = S_RDEND;
                end
            end
            S_NL:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_PUT_NL;
                    state_next = ret_copy_reg ? S_CSTART : S_IDLE;
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.op      = OP_PUT_ERR;
                    halted_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            halted_reg   <= 1'b0;
            ret_copy_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            halted_reg   <= halted_next;
            ret_copy_reg <= ret_copy_next;
        end
    end

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    // Error item sets the halt
    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUT_ERR) |=> halted_reg)
        else $error("error item did not halt the block");

    // Line end only goes out with a free output slot
    a_nl_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_PUT_NL || cmd.op == OP_PUT_ERR) |-> stat.out_free)
        else $error("item pushed into a busy output register");

    // An accepted item is decoded next
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted item not decoded");

endmodule

[rtl/text_full_justifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_full_justifier
// Greedy full justification of a byte stream, up to eight characters per item.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------
//  in_ch    | in        | text_byte[7:0], stream_end
//  out_ch   | out       | packed_chars[63:0], char_count[3:0], line_done,
//           |           | word_too_long
//  APB      | in        | line_width at byte address 0
//
//  A letter is latched and then decoded. A separator also passes the finish
//  step and, when it commits a word, the pending-word copy into the line.
//  A line flush runs the gap divider, then for each word reads its end
//  offset and its characters through the registered reads of the line and
//  word-end memories and puts its padding spaces, and ends with the newline.
//  Reset (rst_n, asynchronous) empties the line and restores width 80.
//  A full output register stalls the flush; input waits until it is done.
// ----------------------------------------------------------------------------
module text_full_justifier (
    input  logic        clk,
    input  logic        rst_n,
    tfj_in_if.sink      in_ch,
    tfj_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tfj_pkg::*;

    cmd_t       cmd;
    stat_t      stat;
    logic [7:0] line_width_reg;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= WIDTH_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_LINE_WIDTH))
        begin
            line_width_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_LINE_WIDTH) ? {24'd0, line_width_reg} : 32'd0;

    tfj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    tfj_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .line_width (line_width_reg),
        .in_byte    (in_ch.text_byte),
        .in_end     (in_ch.stream_end),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_chars  (out_ch.packed_chars),
        .out_count  (out_ch.char_count),
        .out_done   (out_ch.line_done),
        .out_err    (out_ch.word_too_long)
    );

endmodule

[bench/text_full_justifier_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_full_justifier_checker
// Watches the character and output channels and the register port, predicts
// the justified output items of every accepted character and compares them
// field by field with the items the block sends.
// ----------------------------------------------------------------------------
module text_full_justifier_checker (
    input  logic        clk,
    input  logic        rst_n,
    tfj_in_if           in_ch,
    tfj_out_if          out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          pending,
    output int          fails
);
    import tfj_pkg::*;

    typedef struct {
        logic [63:0] chars;
        logic [3:0]  count;
        logic        done;
        logic        err;
    } out_item_t;

    out_item_t   expected_items[$];

    // Predicted state of the block
    logic [7:0]  width_reg;
    logic [7:0]  open_line[MAX_WIDTH];
    int          word_end_at[MAX_WORDS];
    logic [7:0]  word_buf[MAX_WIDTH];
    int          word_len;
    int          open_words;
    int          line_letters;
    bit          stopped;

    assign pending = expected_items.size();

    function automatic int active_width();
        int w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic void push_item(logic [63:0] c, int n, bit d, bit e);
        out_item_t it;
        it.chars = c;
        it.count = 4'(n);
        it.done  = d;
        it.err   = e;
        expected_items.push_back(it);
    endfunction

    function automatic void word_overflow();
        push_item('0, 0, 1'b0, 1'b1);
        stopped      = 1'b1;
        open_words   = 0;
        line_letters = 0;
        word_len     = 0;
    endfunction

    function automatic void flush_line();
        logic [7:0]  text[MAX_WIDTH + 1];
        logic [63:0] word64;
        int n, gaps, pad, base, extra, start, s, cnt;
        n = 0;
        start = 0;
        if (open_words == 0) return;
        if (open_words == 1) begin
            for (int i = 0; i < line_letters && n < MAX_WIDTH; i++) text[n++] = open_line[i];
        end else begin
            gaps  = open_words - 1;
            pad   = (active_width() > line_letters) ? active_width() - line_letters : 0;
            if (pad < gaps) pad = gaps;
            base  = pad / gaps;
            extra = pad % gaps;
            for (int w = 0; w < open_words; w++) begin
                for (int i = start; i < word_end_at[w] && n < MAX_WIDTH; i++)
                    text[n++] = open_line[i];
                start = word_end_at[w];
                if (w < gaps) begin
                    s = base + ((w < extra) ? 1 : 0);
                    while (s > 0 && n < MAX_WIDTH) begin
                        text[n++] = CH_SP;
                        s--;
                    end
                end
            end
        end
        text[n++] = CH_NL;
        // pack up to eight characters per item, lowest byte first
        for (int i = 0; i < n; i += 8) begin
            cnt = (n - i > 8) ? 8 : n - i;
            word64 = '0;
            for (int k = 0; k < cnt; k++) word64[8*k +: 8] = text[i + k];
            push_item(word64, cnt, (i + 8 >= n), 1'b0);
        end
        open_words   = 0;
        line_letters = 0;
    endfunction

    function automatic void close_word();
        if (word_len == 0) return;
        if (word_len > active_width()) begin
            word_overflow();
            return;
        end
        if (open_words > 0 && (line_letters + word_len + open_words > active_width()
                               || open_words >= MAX_WORDS))
            flush_line();
        if (line_letters + word_len > MAX_WIDTH) flush_line();
        for (int i = 0; i < word_len; i++) open_line[line_letters + i] = word_buf[i];
        line_letters += word_len;
        word_end_at[open_words] = line_letters;
        open_words++;
        word_len = 0;
    endfunction

    function automatic void take_char(logic [7:0] b, bit last);
        if (stopped) return;
        if (b == CH_NL) begin
            close_word();
            if (stopped) return;
            flush_line();
        end else if (b == CH_SP || b == CH_TAB) begin
            close_word();
            if (stopped) return;
        end else begin
            if (word_len >= active_width()) begin
                word_overflow();
                return;
            end
            word_buf[word_len] = b;
            word_len++;
        end
        if (last && b != CH_NL) begin
            close_word();
            if (stopped) return;
            flush_line();
        end
    endfunction

    // Track register writes, predict on accepted characters, check output items
    always @(posedge clk or negedge rst_n) begin
        out_item_t exp_it;
        if (!rst_n) begin
            width_reg    <= WIDTH_RESET;
            word_len     = 0;
            open_words   = 0;
            line_letters = 0;
            stopped      = 1'b0;
            fails        = 0;
            expected_items.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_LINE_WIDTH))
                width_reg <= pwdata[7:0];
            if (in_ch.valid && in_ch.ready)
                take_char(in_ch.text_byte, in_ch.stream_end);
            if (out_ch.valid && out_ch.ready) begin
                if (expected_items.size() == 0) begin
                    $error("unexpected output item: chars %h count %0d",
                           out_ch.packed_chars, out_ch.char_count);
                    fails++;
                end else begin
                    exp_it = expected_items.pop_front();
                    if (out_ch.packed_chars !== exp_it.chars) begin
                        $error("packed_chars: expected %h, got %h", exp_it.chars,
                               out_ch.packed_chars);
                        fails++;
                    end
                    if (out_ch.char_count !== exp_it.count) begin
                        $error("char_count: expected %0d, got %0d", exp_it.count,
                               out_ch.char_count);
                        fails++;
                    end
                    if (out_ch.line_done !== exp_it.done) begin
                        $error("line_done: expected %b, got %b", exp_it.done,
                               out_ch.line_done);
                        fails++;
                    end
                    if (out_ch.word_too_long !== exp_it.err) begin
                        $error("word_too_long: expected %b, got %b", exp_it.err,
                               out_ch.word_too_long);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

[bench/text_full_justifier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_full_justifier_tb
// Drives text through the justifier under a series of line widths: a short
// directed set, then random paragraphs with separator runs, empty lines and
// stream ends, a maximal word-count line, a width change with a line still
// open, and finally an over-long word. A separate checker predicts and
// compares all output items.
// ----------------------------------------------------------------------------
module text_full_justifier_tb;
    import tfj_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          pending, fails;
    int          sent;
    int          cur_w;
    bit          quiet;
    bit          hold_req;

    tfj_in_if  in_ch();
    tfj_out_if out_ch();

    text_full_justifier dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    text_full_justifier_checker chk (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .pending(pending), .fails(fails)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #20ms;
        $display("** text_full_justifier: FAILED **");
        $finish;
    end

    // Output side: random stall bursts, one long hold on request
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (2000) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Offer one character and hold it until accepted; valid stays up after
    // the accepting edge so that the next item can follow at once
    task automatic send_char(logic [7:0] b, bit last);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.text_byte  <= b;
        in_ch.stream_end <= last;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    function automatic logic [7:0] rand_letter();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_NL || b == CH_SP || b == CH_TAB);
        return b;
    endfunction

    task automatic send_word(int len);
        for (int i = 0; i < len; i++) send_char(rand_letter(), 1'b0);
    endtask

    task automatic send_gap();
        repeat ($urandom_range(1, 3))
            send_char(($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB, 1'b0);
    endtask

    // Write line_width once the block has drained
    task automatic set_width(logic [7:0] v);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (500) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_LINE_WIDTH);
        pwdata  <= {24'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_w = (v == 0) ? 1 : ((v > MAX_WIDTH) ? MAX_WIDTH : int'(v));
    endtask

    // One input line: mostly well-formed words, sometimes noise
    task automatic random_line();
        int nw, lim, run;
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: any byte, letter runs kept within width
            run = 0;
            repeat ($urandom_range(1, 20))
            begin
                b = 8'($urandom_range(0, 255));
                if (b != CH_NL && b != CH_SP && b != CH_TAB && run >= cur_w) b = CH_TAB;
                run = (b == CH_NL || b == CH_SP || b == CH_TAB) ? 0 : run + 1;
                send_char(b, 1'b0);
            end
            send_char(CH_NL, 1'b0);
            return;
        end
        nw = $urandom_range(0, 8);
        if ($urandom_range(0, 4) == 0) send_gap();
        for (int w = 0; w < nw; w++)
        begin
            if (w > 0) send_gap();
            lim = ($urandom_range(0, 5) == 0 || cur_w < 10) ? cur_w : 10;
            send_word($urandom_range(1, lim));
        end
        case ($urandom_range(0, 7))
            0: send_char(CH_NL, 1'b1);
            1: send_char(rand_letter(), 1'b1);
            2: send_char(CH_SP, 1'b1);
            default: send_char(CH_NL, 1'b0);
        endcase
    endtask

    task automatic random_phase(int n);
        int stop_at;
        stop_at = sent + n;
        while (sent < stop_at) random_line();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        quiet            = 1'b0;
        hold_req         = 1'b0;
        sent             = 0;
        cur_w            = 80;
        in_ch.valid      <= 1'b0;
        in_ch.text_byte  <= '0;
        in_ch.stream_end <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (3) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed: empty line, separator runs, extreme letters, stream ends
        send_char(CH_NL, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(CH_SP, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_SP, 1'b0);
        send_char(8'd13, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(CH_NL, 1'b0);
        send_char(8'h41, 1'b0);
        send_char(8'h80, 1'b1);
        send_char(8'h42, 1'b0);
        send_char(CH_NL, 1'b1);
        send_char(CH_NL, 1'b1);
        send_char(8'h55, 1'b0);
        send_char(CH_SP, 1'b1);
        send_char(8'hAA, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_char(8'h01, 1'b0);
        send_char(CH_NL, 1'b0);

        // Narrowest widths, then out-of-range zero
        set_width(8'd1);
        random_phase(15);
        set_width(8'd0);
        random_phase(10);

        // Widest: a word-count-limited line while the output is held off
        set_width(8'd128);
        hold_req = 1'b1;
        for (int w = 0; w < MAX_WORDS + 2; w++)
        begin
            send_word(1);
            send_char(CH_SP, 1'b0);
        end
        send_char(CH_NL, 1'b0);
        random_phase(15);

        set_width(8'd255);
        random_phase(15);

        // Leave a line open, then narrow the width under it
        set_width(8'd9);
        random_phase(15);
        repeat (4)
        begin
            send_word($urandom_range(1, 9));
            send_char(CH_SP, 1'b0);
        end
        set_width(8'd4);
        send_word(2);
        send_char(CH_NL, 1'b0);
        random_phase(10);

        set_width(8'd40);
        random_phase(20);
        set_width(8'd80);
        random_phase(15);

        // Last stretch without idling, ending with an over-long word
        set_width(8'd16);
        quiet = 1'b1;
        random_phase(20);
        send_word(cur_w + 1);
        send_char(CH_NL, 1'b0);
        send_char(8'h61, 1'b1);
        in_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (500) @(posedge clk);
        if (fails == 0)
            $display("** text_full_justifier: PASSED **");
        else
            $display("** text_full_justifier: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
rtl/tfj_pkg.sv
rtl/tfj_stream_if.sv
rtl/tfj_ram.sv
rtl/tfj_dpath.sv
rtl/tfj_ctrl.sv
rtl/text_full_justifier.sv
bench/text_full_justifier_checker.sv
bench/text_full_justifier_tb.sv
